// File: sv/alid_pkg.sv
// Shared types and constants for the array list insert/delete block.
// No dependencies; imported by every module of the block.
package alid_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PLACE_W  = 2;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [PLACE_W-1:0] {
    PL_FRONT = 2'd0,
    PL_INDEX = 2'd1,
    PL_BACK  = 2'd2
  } place_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_LEFT  = 3'd1,
    OP_RIGHT = 3'd2,
    OP_LOAD  = 3'd3,
    OP_ZERO  = 3'd4
  } cell_op_e;

  typedef logic signed [VAL_W-1:0] val_t;

endpackage

// File: sv/array_list_insert_delete.sv
// Ordered list of signed values held in a chain of cells, with a fill count.
// Result strobe valid_o is registered through v1_q and then v2_q after the accepting edge.
// Throughput: one item per cycle; busy_o stays low, every cell shifts at once.
// Read path: registered OR over groups of cells, then a final OR stage.
// Reset clears all entries and the count; the receiver cannot stall.
module array_list_insert_delete #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [alid_pkg::CMD_W-1:0]        cmd_i,
  input  logic [alid_pkg::PLACE_W-1:0]      place_i,
  input  logic [alid_pkg::IDX_W-1:0]        index_i,
  input  logic signed [alid_pkg::VAL_W-1:0] value_i,
  output logic                              valid_o,
  output logic [alid_pkg::STATUS_W-1:0]     status_o,
  output logic signed [alid_pkg::VAL_W-1:0] read_value_o,
  output logic [alid_pkg::FILL_W-1:0]       fill_count_o
);
  import alid_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned W  = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned G  = 16;
  localparam int unsigned NG = (DEPTH + G - 1) / G;

  cmd_e    cmd;
  place_e  place;
  status_e st;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  cnt_w, idx_w, lim_w, pos_w;
  logic          pos_ok, full, empty, accept;
  logic          ins_go, del_go, rd_go, clr_go;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign cmd    = cmd_e'(cmd_i);
  assign place  = place_e'(place_i);
  assign cnt_w  = W'(cnt_q);
  assign idx_w  = W'(index_i);
  assign full   = (cnt_q == CW'(DEPTH));
  assign empty  = (cnt_q == '0);
  assign lim_w  = (cmd == CMD_INSERT) ? cnt_w : cnt_w - W'(1);

  always_comb begin
    pos_w  = '0;
    pos_ok = 1'b0;
    case (place)
      PL_FRONT: pos_ok = 1'b1;
      PL_BACK: begin
        pos_w  = lim_w;
        pos_ok = 1'b1;
      end
      PL_INDEX: begin
        pos_w  = idx_w;
        pos_ok = (idx_w <= lim_w);
      end
      default: pos_ok = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd)
      CMD_INSERT: st = full ? ST_FULL : (pos_ok ? ST_OK : ST_RANGE);
      CMD_DELETE,
      CMD_READ:   st = empty ? ST_EMPTY : (pos_ok ? ST_OK : ST_RANGE);
      default:    st = ST_OK;
    endcase
  end

  assign ins_go = accept && (cmd == CMD_INSERT) && (st == ST_OK);
  assign del_go = accept && (cmd == CMD_DELETE) && (st == ST_OK);
  assign rd_go  = accept && (cmd == CMD_READ) && (st == ST_OK);
  assign clr_go = accept && (cmd == CMD_CLEAR);

  always_comb begin
    cnt_d = cnt_q;
    if (clr_go) begin
      cnt_d = '0;
    end else if (ins_go) begin
      cnt_d = cnt_q + CW'(1);
    end else if (del_go) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // cell chain
  val_t             ent [DEPTH];
  val_t             ent_pad [NG*G];
  logic [NG*G-1:0]  hit;
  cell_op_e         op [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [W-1:0] kw;
    val_t         left, right;
    assign kw = W'(k);

    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = ent[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = ent[k+1];
    end

    always_comb begin
      op[k] = OP_HOLD;
      if (clr_go) begin
        op[k] = OP_ZERO;
      end else if (ins_go) begin
        if (kw == pos_w) begin
          op[k] = OP_LOAD;
        end else if ((kw > pos_w) && (kw <= cnt_w)) begin
          op[k] = OP_LEFT;
        end
      end else if (del_go) begin
        if (kw == cnt_w - W'(1)) begin
          op[k] = OP_ZERO;
        end else if ((kw >= pos_w) && (kw < cnt_w - W'(1))) begin
          op[k] = OP_RIGHT;
        end
      end
    end

    alid_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op[k]),
      .left_i (left),
      .right_i(right),
      .load_i (value_i),
      .data_o (ent[k])
    );
  end

  for (genvar k = 0; k < NG*G; k++) begin : g_pad
    if (k < DEPTH) begin : g_real
      assign ent_pad[k] = ent[k];
      assign hit[k]     = rd_go && (W'(k) == pos_w);
    end else begin : g_fill
      assign ent_pad[k] = '0;
      assign hit[k]     = 1'b0;
    end
  end

  // read-out tree
  val_t grp_or [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    alid_grp #(.G(G)) u_grp (
      .clk_i (clk_i),
      .data_i(ent_pad[g*G +: G]),
      .hit_i (hit[g*G +: G]),
      .or_o  (grp_or[g])
    );
  end

  val_t rd_all;
  always_comb begin
    rd_all = '0;
    for (int unsigned g = 0; g < NG; g++) begin
      rd_all = rd_all | grp_or[g];
    end
  end

  // result pipeline
  logic          v1_q, v2_q;
  status_e       st1_q, st2_q;
  logic [CW-1:0] cnt1_q, cnt2_q;
  val_t          rd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q  <= accept;
      v2_q  <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q  <= st;
    cnt1_q <= cnt_d;
    st2_q  <= st1_q;
    cnt2_q <= cnt1_q;
    rd2_q  <= rd_all;
  end

  assign valid_o      = v2_q;
  assign status_o     = st2_q;
  assign read_value_o = rd2_q;
  assign fill_count_o = FILL_W'(cnt2_q);

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 2))
    else $error("result strobe without item");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_go |=> (cnt_q == '0))
    else $error("clear left entries");

  a_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_go |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow list");

endmodule

// File: sv/alid_cell.sv
// One list entry: holds, takes a neighbor's entry, loads a new value or clears.
// Depends on alid_pkg.
module alid_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alid_pkg::cell_op_e op_i,
  input  alid_pkg::val_t    left_i,
  input  alid_pkg::val_t    right_i,
  input  alid_pkg::val_t    load_i,
  output alid_pkg::val_t    data_o
);
  import alid_pkg::*;

  val_t data_q, data_d;

  always_comb begin
    unique case (op_i)
      OP_LEFT:  data_d = left_i;
      OP_RIGHT: data_d = right_i;
      OP_LOAD:  data_d = load_i;
      OP_ZERO:  data_d = '0;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// File: sv/alid_grp.sv
// Read-out group: ORs the hit-masked entries of a run of cells into a register.
// Depends on alid_pkg.
module alid_grp #(
  parameter int unsigned G = 16
) (
  input  logic           clk_i,
  input  alid_pkg::val_t data_i [G],
  input  logic [G-1:0]   hit_i,
  output alid_pkg::val_t or_o
);
  import alid_pkg::*;

  val_t or_q, or_d;

  always_comb begin
    or_d = '0;
    for (int unsigned k = 0; k < G; k++) begin
      or_d = or_d | (data_i[k] & {VAL_W{hit_i[k]}});
    end
  end

  always_ff @(posedge clk_i) begin
    or_q <= or_d;
  end

  assign or_o = or_q;

endmodule
